### rtl/wcpd_pkg.sv
// Shared types and constants of the WAV chunk parser with stereo downmix.
package wcpd_pkg;

   // Parser position in the file.
   typedef enum logic [3:0] {
      PH_RIFF,
      PH_SIZE,
      PH_WAVE,
      PH_ID,
      PH_LEN,
      PH_FMT,
      PH_SKIP,
      PH_PAD,
      PH_DATA,
      PH_DONE
   } phase_type;

   // Status codes carried in each result word.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_RIFF  = 3'd1,
      ST_NOT_WAVE  = 3'd2,
      ST_NOT_16BIT = 3'd3,
      ST_NO_DATA   = 3'd4,
      ST_TRUNCATED = 3'd5
   } status_type;

   // Four-character tags, first byte in the top lane.
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // Only 16-bit PCM is played; two channels are averaged.
   localparam logic [15:0] PCM_BITS       = 16'd16;
   localparam logic [15:0] STEREO_CHANNELS = 16'd2;

   // Classified request word as it travels through the queue.
   typedef struct packed {
      logic       is_eof;
      logic [7:0] data;
   } item_type;

   // One result word.
   typedef struct packed {
      logic               has_sample;
      logic signed [15:0] sample;
      logic [31:0]        sample_rate;
      logic [2:0]         status;
      logic               last;
   } result_type;

endpackage

### rtl/wcpd_req_if.sv
// Request channel: one file byte or an end-of-file marker per word.
interface wcpd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_req;

   modport source (output valid, output kind, output byte_req, input ready);
   modport sink (input valid, input kind, input byte_req, output ready);
endinterface

### rtl/wcpd_rsp_if.sv
// Response channel: one sample or status word per handshake.
interface wcpd_rsp_if;
   logic               valid;
   logic               ready;
   logic               has_sample;
   logic signed [15:0] sample;
   logic [31:0]        sample_rate;
   logic [2:0]         status;
   logic               last;

   modport source (output valid, output has_sample, output sample, output sample_rate,
                   output status, output last, input ready);
   modport sink (input valid, input has_sample, input sample, input sample_rate,
                 input status, input last, output ready);
endinterface

### rtl/wav_chunk_parser_downmix_core.sv
// Top level of the WAV chunk parser with stereo downmix.
// The req channel takes one word per file byte (kind low, byte in byte_req)
// and one end-of-file word (kind high) that closes the file and rearms the parser.
// The rsp channel returns at most one word per request word: a 16-bit sample
// (stereo frames averaged, rounded toward zero), the sample rate of the last
// fmt chunk, a status code and a last flag on the final word of each file.
// Header bytes, skipped chunks and left halves of stereo frames produce no word.
// A request word passes a classifying input register, a two-entry queue and
// the parser, whose result lands in an output register.
// Throughput is one request word per cycle while the receiver takes every
// response word; the parser updates its state once per byte.
// Synchronous reset clears the queue, the output register and all parser
// state; the parser then expects the RIFF tag.
// When the receiver stalls, the output register holds its word, the queue
// fills, and req ready drops only once the input register is also occupied.
module wav_chunk_parser_downmix_core
   import wcpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   wcpd_req_if.sink    req_if,
   wcpd_rsp_if.source  rsp_if
);

   logic     push_valid;
   item_type push_item;
   logic     push_ready;
   logic     head_valid;
   item_type head_item;
   logic     pop;

   wcpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   wcpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   wcpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

### rtl/wcpd_front.sv
// Front end: accepts request words, classifies them and hands them to the queue.
module wcpd_front
   import wcpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   wcpd_req_if.sink        req_if,
   output logic            push_valid,
   output item_type        push_item,
   input  logic            push_ready
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   item_type classified;
   logic     take, leave;

   // A held word leaves when the queue has room; a new word may enter the same cycle.
   assign req_if.ready = !valid_ff || push_ready;
   assign take         = req_if.valid && req_if.ready;
   assign leave        = valid_ff && push_ready;

   // End-of-file words carry no byte.
   always_comb begin
      classified.is_eof = req_if.kind;
      classified.data   = req_if.kind ? 8'd0 : req_if.byte_req;
   end

   always_comb begin
      valid_in = take || (valid_ff && !leave);
      item_in  = take ? classified : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

### rtl/wcpd_queue.sv
// Two-entry queue between the classifying front end and the parser.
module wcpd_queue
   import wcpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     head_valid,
   output item_type head_item,
   input  logic     pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/wcpd_back.sv
// Back end: RIFF/WAVE parser state machine with downmix and an output register.
module wcpd_back
   import wcpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  item_type head_item,
   output logic     pop,
   wcpd_rsp_if.source rsp_if
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] left_ff, left_in;
   logic [1:0]  sp_ff, sp_in;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;

   logic        res_valid;
   result_type  res;
   logic [31:0] tag_next;
   logic [31:0] len_full;
   logic [15:0] raw;
   logic [16:0] sum;
   logic [16:0] sum_adj;
   logic        data_end;
   logic [7:0]  b;

   // The parser steps whenever a word waits and the output slot is free or draining.
   assign pop = head_valid && (!out_valid_ff || rsp_if.ready);
   assign b   = head_item.data;

   // Byte assembly helpers and the rounding-toward-zero average.
   always_comb begin
      tag_next = {tag_ff[23:0], b};
      len_full = {b, len_ff[23:0]};
      raw      = {b, low_ff};
      sum      = {raw[15], raw} + {left_ff[15], left_ff};
      sum_adj  = sum + {16'd0, sum[16]};
      data_end = (len_ff == 32'd1);
   end

   // Next state and result of one parser step.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      chan_in  = chan_ff;
      rate_in  = rate_ff;
      bits_in  = bits_ff;
      low_in   = low_ff;
      left_in  = left_ff;
      sp_in    = sp_ff;

      res_valid       = 1'b0;
      res.has_sample  = 1'b0;
      res.sample      = 16'sd0;
      res.sample_rate = rate_ff;
      res.status      = ST_OK;
      res.last        = 1'b0;

      if (head_item.is_eof) begin
         // End of file: report where it fell unless the file is already done, then rearm everything.
         res_valid = (phase_ff != PH_DONE);
         res.last  = 1'b1;
         unique case (phase_ff)
            PH_RIFF:          res.status = ST_NOT_RIFF;
            PH_SIZE, PH_WAVE: res.status = ST_NOT_WAVE;
            PH_DATA:          res.status = ST_TRUNCATED;
            default:          res.status = ST_NO_DATA;
         endcase
         phase_in = PH_RIFF;
         count_in = 4'd0;
         tag_in   = 32'd0;
         len_in   = 32'd0;
         chan_in  = 16'd0;
         rate_in  = 32'd0;
         bits_in  = 16'd0;
         low_in   = 8'd0;
         left_in  = 16'd0;
         sp_in    = 2'd0;
      end else begin
         unique case (phase_ff)
            PH_RIFF, PH_WAVE: begin
               tag_in   = tag_next;
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd3) begin
                  count_in = 4'd0;
                  tag_in   = 32'd0;
                  if (phase_ff == PH_RIFF) begin
                     if (tag_next != TAG_RIFF) begin
                        phase_in   = PH_DONE;
                        res_valid  = 1'b1;
                        res.status = ST_NOT_RIFF;
                        res.last   = 1'b1;
                     end else begin
                        phase_in = PH_SIZE;
                     end
                  end else begin
                     if (tag_next != TAG_WAVE) begin
                        phase_in   = PH_DONE;
                        res_valid  = 1'b1;
                        res.status = ST_NOT_WAVE;
                        res.last   = 1'b1;
                     end else begin
                        phase_in = PH_ID;
                     end
                  end
               end
            end
            PH_SIZE: begin
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd3) begin
                  count_in = 4'd0;
                  phase_in = PH_WAVE;
               end
            end
            PH_ID: begin
               tag_in   = tag_next;
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd3) begin
                  count_in = 4'd0;
                  len_in   = 32'd0;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               // Little-endian chunk length, one lane per byte.
               case (count_ff[1:0])
                  2'd0:    len_in = {len_ff[31:8], b};
                  2'd1:    len_in = {len_ff[31:16], b, len_ff[7:0]};
                  2'd2:    len_in = {len_ff[31:24], b, len_ff[15:0]};
                  default: len_in = len_full;
               endcase
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd3) begin
                  count_in = 4'd0;
                  if (tag_ff == TAG_FMT) begin
                     phase_in = PH_FMT;
                  end else if (tag_ff == TAG_DATA) begin
                     if (bits_ff != PCM_BITS) begin
                        phase_in   = PH_DONE;
                        res_valid  = 1'b1;
                        res.status = ST_NOT_16BIT;
                        res.last   = 1'b1;
                     end else if (len_full == 32'd0) begin
                        phase_in  = PH_DONE;
                        res_valid = 1'b1;
                        res.last  = 1'b1;
                     end else begin
                        sp_in    = 2'd0;
                        phase_in = PH_DATA;
                     end
                  end else if (len_full == 32'd0) begin
                     phase_in = PH_ID;
                     tag_in   = 32'd0;
                  end else begin
                     sp_in    = {1'b0, len_full[0]};
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               // Pick channel count, rate and bits per sample out of the body.
               case (count_ff)
                  4'd2:    chan_in = {chan_ff[15:8], b};
                  4'd3:    chan_in = {b, chan_ff[7:0]};
                  4'd4:    rate_in = {rate_ff[31:8], b};
                  4'd5:    rate_in = {rate_ff[31:16], b, rate_ff[7:0]};
                  4'd6:    rate_in = {rate_ff[31:24], b, rate_ff[15:0]};
                  4'd7:    rate_in = {b, rate_ff[23:0]};
                  4'd14:   bits_in = {bits_ff[15:8], b};
                  4'd15:   bits_in = {b, bits_ff[7:0]};
                  default: chan_in = chan_ff;
               endcase
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd15) begin
                  if (len_ff > 32'd16) begin
                     sp_in    = {1'b0, len_ff[0]};
                     len_in   = len_ff - 32'd16;
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_ID;
                     count_in = 4'd0;
                     tag_in   = 32'd0;
                  end
               end
            end
            PH_SKIP: begin
               len_in = len_ff - 32'd1;
               if (len_ff == 32'd1) begin
                  if (sp_ff[0]) begin
                     sp_in    = 2'd0;
                     phase_in = PH_PAD;
                  end else begin
                     phase_in = PH_ID;
                     count_in = 4'd0;
                     tag_in   = 32'd0;
                  end
               end
            end
            PH_PAD: begin
               phase_in = PH_ID;
               count_in = 4'd0;
               tag_in   = 32'd0;
            end
            PH_DATA: begin
               // The length register counts the bytes still to come.
               len_in = len_ff - 32'd1;
               if (!sp_ff[0]) begin
                  low_in = b;
                  sp_in  = sp_ff | 2'b01;
               end else if (chan_ff == STEREO_CHANNELS) begin
                  if (sp_ff[1]) begin
                     res.sample     = sum_adj[16:1];
                     res.has_sample = 1'b1;
                     sp_in          = 2'd0;
                  end else begin
                     left_in = raw;
                     sp_in   = 2'b10;
                  end
               end else begin
                  res.sample     = raw;
                  res.has_sample = 1'b1;
                  sp_in          = 2'd0;
               end
               if (data_end) begin
                  phase_in = PH_DONE;
               end
               res.last  = data_end;
               res_valid = res.has_sample || data_end;
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   // Output register: refilled as it drains, held while the receiver stalls.
   always_comb begin
      out_in = out_ff;
      if (pop) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_in = res;
         end
      end else begin
         out_valid_in = out_valid_ff && !rsp_if.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         count_ff     <= 4'd0;
         tag_ff       <= 32'd0;
         len_ff       <= 32'd0;
         chan_ff      <= 16'd0;
         rate_ff      <= 32'd0;
         bits_ff      <= 16'd0;
         low_ff       <= 8'd0;
         left_ff      <= 16'd0;
         sp_ff        <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            tag_ff   <= tag_in;
            len_ff   <= len_in;
            chan_ff  <= chan_in;
            rate_ff  <= rate_in;
            bits_ff  <= bits_in;
            low_ff   <= low_in;
            left_ff  <= left_in;
            sp_ff    <= sp_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.has_sample  = out_ff.has_sample;
   assign rsp_if.sample      = out_ff.sample;
   assign rsp_if.sample_rate = out_ff.sample_rate;
   assign rsp_if.status      = out_ff.status;
   assign rsp_if.last        = out_ff.last;

endmodule

### bench/wav_chunk_parser_downmix_checker.sv
// Checker for the WAV chunk parser: predicts response words from accepted request words and compares.
module wav_chunk_parser_downmix_checker
   import wcpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   wcpd_req_if  req_mon,
   wcpd_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   // Parser state as the predictor tracks it.
   phase_type   phase = PH_RIFF;
   logic [31:0] field_count = '0;
   logic [31:0] tag_bytes = '0;
   logic [31:0] chunk_len = '0;
   logic [15:0] channels = '0;
   logic [31:0] rate = '0;
   logic [15:0] bits_per_sample = '0;
   logic [7:0]  low_half = '0;
   logic [15:0] left_half = '0;
   logic [1:0]  frame_pos = '0;

   // Response words predicted but not yet seen, oldest first.
   result_type  expected_words[$];
   int          failures = 0;
   int          waiting = 0;

   assign mismatch_count = failures;
   assign pending_count  = waiting;

   // Return every part of the parser state to its value after reset.
   task automatic clear_parser();
      phase           = PH_RIFF;
      field_count     = '0;
      tag_bytes       = '0;
      chunk_len       = '0;
      channels        = '0;
      rate            = '0;
      bits_per_sample = '0;
      low_half        = '0;
      left_half       = '0;
      frame_pos       = '0;
   endtask

   // The next byte starts a chunk header.
   task automatic start_chunk_id();
      phase       = PH_ID;
      field_count = '0;
      tag_bytes   = '0;
   endtask

   task automatic push_result(input logic has, input logic [15:0] value,
                              input status_type code, input logic fin);
      result_type r;
      r.has_sample  = has;
      r.sample      = value;
      r.sample_rate = rate;
      r.status      = code;
      r.last        = fin;
      expected_words.push_back(r);
   endtask

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   // Advance the predicted parser by one request word.
   task automatic predict_word(input logic is_eof, input logic [7:0] b);
      logic [3:0]  k;
      logic [15:0] raw;
      logic        emit;
      logic        finished;
      int          mixed;
      int          left_value;
      int          right_value;
      if (is_eof) begin
         // End of file reports where the parser stood, unless it is done, then rearms it.
         case (phase)
            PH_RIFF: push_result(1'b0, '0, ST_NOT_RIFF, 1'b1);
            PH_SIZE, PH_WAVE: push_result(1'b0, '0, ST_NOT_WAVE, 1'b1);
            PH_DATA: push_result(1'b0, '0, ST_TRUNCATED, 1'b1);
            PH_DONE: ;
            default: push_result(1'b0, '0, ST_NO_DATA, 1'b1);
         endcase
         clear_parser();
         return;
      end
      case (phase)
         PH_RIFF, PH_WAVE: begin
            tag_bytes   = {tag_bytes[23:0], b};
            field_count = field_count + 1;
            if (field_count == 32'd4) begin
               field_count = '0;
               if (phase == PH_RIFF) begin
                  if (tag_bytes != TAG_RIFF) begin
                     phase = PH_DONE;
                     push_result(1'b0, '0, ST_NOT_RIFF, 1'b1);
                  end else begin
                     phase     = PH_SIZE;
                     tag_bytes = '0;
                  end
               end else if (tag_bytes != TAG_WAVE) begin
                  phase = PH_DONE;
                  push_result(1'b0, '0, ST_NOT_WAVE, 1'b1);
               end else begin
                  start_chunk_id();
               end
            end
         end
         PH_SIZE: begin
            field_count = field_count + 1;
            if (field_count == 32'd4) begin
               field_count = '0;
               phase       = PH_WAVE;
            end
         end
         PH_ID: begin
            tag_bytes   = {tag_bytes[23:0], b};
            field_count = field_count + 1;
            if (field_count == 32'd4) begin
               field_count = '0;
               chunk_len   = '0;
               phase       = PH_LEN;
            end
         end
         PH_LEN: begin
            // Chunk length arrives little-endian.
            chunk_len   = chunk_len | (32'(b) << (8 * field_count[1:0]));
            field_count = field_count + 1;
            if (field_count == 32'd4) begin
               field_count = '0;
               if (tag_bytes == TAG_FMT) begin
                  phase = PH_FMT;
               end else if (tag_bytes == TAG_DATA) begin
                  if (bits_per_sample != PCM_BITS) begin
                     phase = PH_DONE;
                     push_result(1'b0, '0, ST_NOT_16BIT, 1'b1);
                  end else if (chunk_len == '0) begin
                     phase = PH_DONE;
                     push_result(1'b0, '0, ST_OK, 1'b1);
                  end else begin
                     frame_pos = '0;
                     phase     = PH_DATA;
                  end
               end else if (chunk_len == '0) begin
                  start_chunk_id();
               end else begin
                  frame_pos = {1'b0, chunk_len[0]};
                  phase     = PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            // Only the first 16 body bytes are read; the rest is skipped.
            k = field_count[3:0];
            case (k)
               4'd2:  channels[7:0] = b;
               4'd3:  channels[15:8] = b;
               4'd4, 4'd5, 4'd6, 4'd7: rate[8 * k[1:0] +: 8] = b;
               4'd14: bits_per_sample[7:0] = b;
               4'd15: bits_per_sample[15:8] = b;
               default: ;
            endcase
            field_count = field_count + 1;
            if (k == 4'd15) begin
               if (chunk_len > 32'd16) begin
                  frame_pos = {1'b0, chunk_len[0]};
                  chunk_len = chunk_len - 32'd16;
                  phase     = PH_SKIP;
               end else begin
                  start_chunk_id();
               end
            end
         end
         PH_SKIP: begin
            // While skipping, frame_pos holds the pad flag of an odd chunk.
            chunk_len = chunk_len - 1;
            if (chunk_len == '0) begin
               if (frame_pos != '0) begin
                  frame_pos = '0;
                  phase     = PH_PAD;
               end else begin
                  start_chunk_id();
               end
            end
         end
         PH_PAD: start_chunk_id();
         PH_DATA: begin
            emit        = 1'b0;
            mixed       = 0;
            field_count = field_count + 1;
            if (!frame_pos[0]) begin
               low_half     = b;
               frame_pos[0] = 1'b1;
            end else begin
               raw = {b, low_half};
               if (channels == STEREO_CHANNELS) begin
                  if (frame_pos[1]) begin
                     // Stereo average, truncated toward zero.
                     left_value  = int'($signed(left_half));
                     right_value = int'($signed(raw));
                     mixed       = (left_value + right_value) / 2;
                     emit        = 1'b1;
                     frame_pos   = '0;
                  end else begin
                     left_half = raw;
                     frame_pos = 2'd2;
                  end
               end else begin
                  mixed     = int'($signed(raw));
                  emit      = 1'b1;
                  frame_pos = '0;
               end
            end
            finished = (field_count == chunk_len);
            if (finished) phase = PH_DONE;
            if (emit || finished) push_result(emit, mixed[15:0], ST_OK, finished);
         end
         PH_DONE: ;
         default: phase = PH_DONE;
      endcase
   endtask

   // Watch both channels; compare each response word with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         clear_parser();
         expected_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.has_sample  = rsp_mon.has_sample;
            got.sample      = rsp_mon.sample;
            got.sample_rate = rsp_mon.sample_rate;
            got.status      = rsp_mon.status;
            got.last        = rsp_mon.last;
            if (expected_words.size() == 0) begin
               note_failure($sformatf(
                  "unexpected word: has=%0d sample=%0d rate=%0h status=%0d last=%0d",
                  got.has_sample, got.sample, got.sample_rate, got.status, got.last));
            end else begin
               want = expected_words.pop_front();
               if (got.has_sample !== want.has_sample || got.sample !== want.sample ||
                   got.sample_rate !== want.sample_rate || got.status !== want.status ||
                   got.last !== want.last) begin
                  note_failure($sformatf(
                     {"mismatch: expected has=%0d sample=%0d rate=%0h status=%0d last=%0d,",
                      " got has=%0d sample=%0d rate=%0h status=%0d last=%0d"},
                     want.has_sample, want.sample, want.sample_rate, want.status, want.last,
                     got.has_sample, got.sample, got.sample_rate, got.status, got.last));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) predict_word(req_mon.kind, req_mon.byte_req);
      end
      waiting <= expected_words.size();
   end

endmodule

### bench/wav_chunk_parser_downmix_core_tb.sv
// Testbench top for the WAV chunk parser: builds WAV byte streams and gives the verdict.
module wav_chunk_parser_downmix_core_tb;
   import wcpd_pkg::*;

   localparam int STIMULUS_WORDS = 1650;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 16;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_kind = 1'b0;
   logic [7:0] req_byte = 8'h00;
   logic       rsp_ready = 1'b0;
   int         mismatch_count;
   int         pending_count;
   int         cycle_count = 0;
   int         words_sent = 0;
   int         burst_left = 0;
   int         stall_left = 0;
   int         quiet_left = 0;
   logic [7:0] file_bytes[$];

   wcpd_req_if req_ch();
   wcpd_rsp_if rsp_ch();

   assign req_ch.valid    = req_valid;
   assign req_ch.kind     = req_kind;
   assign req_ch.byte_req = req_byte;
   assign rsp_ch.ready    = rsp_ready;

   wav_chunk_parser_downmix_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   wav_chunk_parser_downmix_checker parse_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #1 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: short random stalls, with quiet stretches of constant readiness.
   always @(posedge clock) begin
      if (quiet_left > 0) begin
         quiet_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         case ($urandom_range(0, 15))
            0: quiet_left = $urandom_range(20, 120);
            1, 2, 3, 4: stall_left = $urandom_range(1, 5);
            default: ;
         endcase
      end
   end

   // Send one request word; the sender works in bursts with idle gaps between them.
   task automatic send_word(input logic is_eof, input logic [7:0] b);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind  <= is_eof;
      req_byte  <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   // Send the assembled file followed by its end-of-file word.
   task automatic send_file();
      foreach (file_bytes[i]) send_word(1'b0, file_bytes[i]);
      send_word(1'b1, 8'($urandom));
   endtask

   function automatic void add_tag(input logic [31:0] t);
      file_bytes.push_back(t[31:24]);
      file_bytes.push_back(t[23:16]);
      file_bytes.push_back(t[15:8]);
      file_bytes.push_back(t[7:0]);
   endfunction

   function automatic void add_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(v[8 * i +: 8]);
   endfunction

   function automatic void add_random_bytes(input int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
   endfunction

   // Sample values lean on the extremes so the averaging corners get exercised.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 10))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   // A chunk of unknown id that the parser has to skip, odd lengths padded.
   function automatic void add_unknown_chunk();
      int len;
      len = $urandom_range(0, 9);
      add_tag($urandom);
      add_le(len, 4);
      add_random_bytes(len);
      if (len % 2 == 1) add_random_bytes(1);
   endfunction

   // Build one random file: mostly well formed, some with broken tags, missing
   // pieces, odd formats, truncation or noise.
   task automatic build_random_file();
      int          style;
      int          fmt_len;
      int          provided;
      int          cut;
      logic [15:0] chans;
      logic [15:0] bits;
      logic [31:0] declared;
      file_bytes.delete();
      style = $urandom_range(0, 31);
      if (style == 0) begin
         add_random_bytes($urandom_range(0, 12));
         return;
      end
      add_tag(style == 1 ? {TAG_RIFF[31:8], 8'($urandom)} : TAG_RIFF);
      add_le($urandom, 4);
      add_tag(style == 2 ? {8'($urandom), TAG_WAVE[23:0]} : TAG_WAVE);
      repeat ($urandom_range(0, 2)) add_unknown_chunk();

      // Format chunk, sometimes with extra bytes or a short declared length.
      if (style != 3) begin
         case ($urandom_range(0, 7))
            0, 1: fmt_len = 16 + $urandom_range(1, 7);
            2:    fmt_len = $urandom_range(0, 15);
            default: fmt_len = 16;
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: chans = 16'd1;
            8: chans = 16'd0;
            9: chans = 16'($urandom);
            default: chans = STEREO_CHANNELS;
         endcase
         if (style == 4) begin
            case ($urandom_range(0, 2))
               0: bits = 16'd8;
               1: bits = 16'd24;
               default: bits = 16'($urandom);
            endcase
         end else begin
            bits = PCM_BITS;
         end
         add_tag(TAG_FMT);
         add_le(fmt_len, 4);
         add_le(32'd1, 2);
         add_le(32'(chans), 2);
         add_le($urandom, 4);
         add_le($urandom, 4);
         add_le($urandom, 2);
         add_le(32'(bits), 2);
         if (fmt_len > 16) begin
            add_random_bytes(fmt_len - 16);
            if (fmt_len % 2 == 1) add_random_bytes(1);
         end
      end
      if ($urandom_range(0, 3) == 0) add_unknown_chunk();
      if (style == 5) return;

      // Data chunk; a few declare more bytes than the file holds.
      provided = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 48);
      declared = provided;
      if (style == 6) declared = provided + $urandom_range(1, 3);
      if (style == 7) declared = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      add_tag(TAG_DATA);
      add_le(declared, 4);
      for (int i = 0; i + 1 < provided; i += 2) add_le(32'(pick_sample()), 2);
      if (provided % 2 == 1) add_random_bytes(1);
      if ($urandom_range(0, 3) == 0) add_random_bytes($urandom_range(1, 4));

      // Cut the file anywhere to hit end of file in every parser position.
      if (style == 8 && file_bytes.size() > 0) begin
         cut = $urandom_range(0, file_bytes.size() - 1);
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty file.
      file_bytes.delete();
      send_file();
      // Bad RIFF tag, then bytes that the finished parser ignores.
      file_bytes.delete();
      add_tag(32'h5249_4658);
      add_random_bytes(2);
      send_file();
      // End of file inside the size field.
      file_bytes.delete();
      add_tag(TAG_RIFF);
      add_random_bytes(2);
      send_file();
      // Bad WAVE tag.
      file_bytes.delete();
      add_tag(TAG_RIFF);
      add_le(32'hFFFF_FFFF, 4);
      add_tag(32'h5741_5646);
      send_file();

      while (words_sent < STIMULUS_WORDS) begin
         build_random_file();
         send_file();
      end
      req_valid <= 1'b0;

      // Drain every predicted word, then allow for the pipeline depth.
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
rtl/wcpd_pkg.sv
rtl/wcpd_req_if.sv
rtl/wcpd_rsp_if.sv
rtl/wcpd_front.sv
rtl/wcpd_queue.sv
rtl/wcpd_back.sv
rtl/wav_chunk_parser_downmix_core.sv
bench/wav_chunk_parser_downmix_checker.sv
bench/wav_chunk_parser_downmix_core_tb.sv
